@@ hdl/mscore_pkg.sv @@
package mscore_pkg;

   typedef logic [31:0] word_type;
   typedef logic [4:0]  reg_index_type;
   typedef logic [5:0]  opcode_type;

   typedef enum logic [1:0] {
      KIND_EXEC       = 2'd0,
      KIND_HOST_WRITE = 2'd1,
      KIND_HOST_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ALU_ADDU = 3'd1,
      ALU_SUBU = 3'd3,
      ALU_AND  = 3'd4,
      ALU_OR   = 3'd5,
      ALU_NOR  = 3'd7
   } alu_op_type;

   localparam opcode_type OP_RTYPE = 6'h00;
   localparam opcode_type OP_J     = 6'h02;
   localparam opcode_type OP_BEQ   = 6'h04;
   localparam opcode_type OP_ADDIU = 6'h09;
   localparam opcode_type OP_LW    = 6'h23;
   localparam opcode_type OP_SW    = 6'h2B;

   localparam word_type HALT_WORD     = 32'hFFFF_FFFF;
   localparam word_type PC_STEP       = 32'd4;
   localparam int       LOAD_ADDR_MAX = 65535;

endpackage

@@ hdl/mscore_if.sv @@
interface mscore_req_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            item_kind;
   mscore_pkg::word_type  instruction_word;
   logic [15:0]           host_address;
   logic [7:0]            host_byte;

   modport source (output valid, item_kind, instruction_word, host_address, host_byte,
                   input ready);
   modport sink   (input valid, item_kind, instruction_word, host_address, host_byte,
                   output ready);
endinterface

interface mscore_rsp_if;
   logic                       valid;
   logic                       ready;
   mscore_pkg::word_type       next_pc;
   logic                       halted;
   logic                       fault;
   logic                       writeback_valid;
   mscore_pkg::reg_index_type  writeback_index;
   mscore_pkg::word_type       writeback_value;
   logic [7:0]                 host_read_value;

   modport source (output valid, next_pc, halted, fault, writeback_valid, writeback_index,
                   writeback_value, host_read_value, input ready);
   modport sink   (input valid, next_pc, halted, fault, writeback_valid, writeback_index,
                   writeback_value, host_read_value, output ready);
endinterface

@@ hdl/mips_subset_single_cycle_core_top.sv @@
// Channel    Direction  Carries
// req_chan   in         item kind, instruction word, host byte address and data
// rsp_chan   out        next PC, halted, fault, register writeback, host read byte
//
// One word is taken per cycle unless rsp_chan stalls; a word passes the execute register, then the result register.
// Register file reads are registered at acceptance; data memory (four byte-wide banks)
// is read and written as the word leaves the execute register, so results forward.
// Reset is synchronous and clears PC, ALU result, halt flag, stage valid bits and register valid bits.
// A stall on rsp_chan holds both stages; req_chan stays ready while the execute stage
// is empty or able to move on.
module mips_subset_single_cycle_core_top #(
   parameter int DATA_MEM_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   mscore_req_if.sink           req_chan,
   mscore_rsp_if.source         rsp_chan
);

   localparam int Rows = DATA_MEM_BYTES / 4;
   localparam int AW   = $clog2(DATA_MEM_BYTES);
   localparam int RW   = AW - 2;

   // Handshake control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_free, s1_go, req_go, wb_go;

   // Execute stage word
   logic [1:0]                 s1_kind_ff;
   mscore_pkg::word_type       s1_insn_ff;
   logic [15:0]                s1_haddr_ff;
   logic [7:0]                 s1_hbyte_ff;

   // Architectural state
   mscore_pkg::word_type       pc_ff, pc_in;
   mscore_pkg::word_type       last_alu_ff, last_alu_in;
   logic                       stopped_ff, stopped_in;

   // Register file
   mscore_pkg::word_type       rf_mem [32];
   logic [31:0]                rf_valid_ff;
   mscore_pkg::word_type       rf_a_ff, rf_b_ff;
   logic                       rf_a_ok_ff, rf_b_ok_ff;
   logic                       last_valid_ff;
   mscore_pkg::reg_index_type  last_idx_ff;
   mscore_pkg::word_type       last_val_ff;

   // Result stage
   mscore_pkg::word_type       s2_pc_ff;
   logic                       s2_halted_ff, s2_fault_ff;
   logic                       s2_wb_valid_ff;
   mscore_pkg::reg_index_type  s2_wb_idx_ff;
   mscore_pkg::word_type       s2_alu_ff;
   logic                       s2_load_ff, s2_hread_ff;
   logic [1:0]                 s2_lane_ff;
   logic [7:0]                 bank_rd_ff [4];
   mscore_pkg::word_type       load_word, s2_value;

   // Execute logic
   mscore_pkg::opcode_type     opcode;
   mscore_pkg::reg_index_type  rs, rt, rd, dest;
   mscore_pkg::word_type       a, b, zimm, simm, alu_b, alu_sum, alu_res, pc_plus4;
   mscore_pkg::word_type       byte_addr;
   logic [2:0]                 alu_op;
   logic                       is_exec, is_halt, is_rtype, is_addiu, is_lw, is_sw;
   logic                       is_mem, uses_alu, addr_fault, retire, wb_en;
   logic                       host_wr, host_rd;
   logic [AW-1:0]              base;
   logic [RW-1:0]              row_base;
   logic [1:0]                 lane0;
   logic [3:0][7:0]            b_bytes;
   logic [RW-1:0]              bank_row [4];
   logic [7:0]                 bank_wdata [4];
   logic                       bank_we [4];

   assign s2_free     = !s2_valid_ff || rsp_chan.ready;
   assign s1_go       = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || s2_free;
   assign req_go      = req_chan.valid && req_chan.ready;
   assign wb_go       = s2_valid_ff && rsp_chan.ready && s2_wb_valid_ff;

   assign s1_valid_in = req_go ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : s2_valid_ff);

   // Operand fetch with forwarding from the result stage and the most recent write.
   assign opcode = s1_insn_ff[31:26];
   assign rs     = s1_insn_ff[25:21];
   assign rt     = s1_insn_ff[20:16];
   assign rd     = s1_insn_ff[15:11];

   assign load_word = {bank_rd_ff[s2_lane_ff], bank_rd_ff[s2_lane_ff + 2'd1],
                       bank_rd_ff[s2_lane_ff + 2'd2], bank_rd_ff[s2_lane_ff + 2'd3]};
   assign s2_value  = s2_load_ff ? load_word : s2_alu_ff;

   always_comb begin
      priority if (s2_valid_ff && s2_wb_valid_ff && s2_wb_idx_ff == rs) begin
         a = s2_value;
      end else if (last_valid_ff && last_idx_ff == rs) begin
         a = last_val_ff;
      end else begin
         a = rf_a_ok_ff ? rf_a_ff : '0;
      end
      priority if (s2_valid_ff && s2_wb_valid_ff && s2_wb_idx_ff == rt) begin
         b = s2_value;
      end else if (last_valid_ff && last_idx_ff == rt) begin
         b = last_val_ff;
      end else begin
         b = rf_b_ok_ff ? rf_b_ff : '0;
      end
   end

   assign is_exec  = (s1_kind_ff == mscore_pkg::KIND_EXEC) && !stopped_ff;
   assign is_halt  = s1_insn_ff == mscore_pkg::HALT_WORD;
   assign is_rtype = opcode == mscore_pkg::OP_RTYPE;
   assign is_addiu = opcode == mscore_pkg::OP_ADDIU;
   assign is_lw    = opcode == mscore_pkg::OP_LW;
   assign is_sw    = opcode == mscore_pkg::OP_SW;
   assign is_mem   = is_lw || is_sw;
   assign host_wr  = s1_kind_ff == mscore_pkg::KIND_HOST_WRITE;
   assign host_rd  = s1_kind_ff == mscore_pkg::KIND_HOST_READ;

   assign zimm = {16'b0, s1_insn_ff[15:0]};
   assign simm = {{16{s1_insn_ff[15]}}, s1_insn_ff[15:0]};

   always_comb begin
      priority if (is_rtype) begin
         alu_b  = b;
         alu_op = s1_insn_ff[2:0];
      end else if (is_addiu) begin
         alu_b  = zimm;
         alu_op = mscore_pkg::ALU_ADDU;
      end else begin
         alu_b  = simm;
         alu_op = mscore_pkg::ALU_ADDU;
      end
   end

   assign alu_sum = a + alu_b;

   always_comb begin
      unique case (mscore_pkg::alu_op_type'(alu_op))
         mscore_pkg::ALU_ADDU: alu_res = alu_sum;
         mscore_pkg::ALU_SUBU: alu_res = a - alu_b;
         mscore_pkg::ALU_AND:  alu_res = a & alu_b;
         mscore_pkg::ALU_OR:   alu_res = a | alu_b;
         mscore_pkg::ALU_NOR:  alu_res = ~(a | alu_b);
         default:              alu_res = last_alu_ff;
      endcase
   end

   assign uses_alu   = is_exec && !is_halt && (is_rtype || is_addiu || is_mem);
   assign addr_fault = is_exec && !is_halt && is_mem
                       && (alu_sum > 32'(mscore_pkg::LOAD_ADDR_MAX));
   assign retire     = is_exec && !is_halt && !addr_fault;
   assign dest       = is_rtype ? rd : rt;
   assign wb_en      = retire && (is_rtype || is_addiu || is_lw) && (dest != '0);

   assign last_alu_in = uses_alu ? alu_res : last_alu_ff;
   assign stopped_in  = stopped_ff || (is_exec && (is_halt || addr_fault));
   assign pc_plus4    = pc_ff + mscore_pkg::PC_STEP;

   always_comb begin
      priority if (!retire) begin
         pc_in = pc_ff;
      end else if (opcode == mscore_pkg::OP_BEQ && a == b) begin
         pc_in = pc_plus4 + {simm[29:0], 2'b00};
      end else if (opcode == mscore_pkg::OP_J) begin
         pc_in = {pc_plus4[31:28], s1_insn_ff[25:0], 2'b00};
      end else begin
         pc_in = pc_plus4;
      end
   end

   // Data memory lanes: byte address n lives in bank n mod 4, row n / 4.
   assign byte_addr = (host_wr || host_rd) ? {16'b0, s1_haddr_ff} : alu_sum;
   assign base      = byte_addr[AW-1:0];
   assign lane0     = base[1:0];
   assign row_base  = base[AW-1:2];
   assign b_bytes   = b;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         bank_row[k] = row_base + RW'(2'(k) < lane0);
         if (host_wr) begin
            bank_wdata[k] = s1_hbyte_ff;
            bank_we[k]    = 2'(k) == lane0;
         end else begin
            bank_wdata[k] = b_bytes[2'd3 - 2'(2'(k) - lane0)];
            bank_we[k]    = retire && is_sw;
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [7:0] mem [Rows];
      always_ff @(posedge clock) begin
         if (s1_go) begin
            if (bank_we[g]) begin
               mem[bank_row[g]] <= bank_wdata[g];
            end
            bank_rd_ff[g] <= mem[bank_row[g]];
         end
      end
   end

   // Register file storage
   always_ff @(posedge clock) begin
      if (req_go) begin
         rf_a_ff    <= rf_mem[req_chan.instruction_word[25:21]];
         rf_b_ff    <= rf_mem[req_chan.instruction_word[20:16]];
         rf_a_ok_ff <= rf_valid_ff[req_chan.instruction_word[25:21]];
         rf_b_ok_ff <= rf_valid_ff[req_chan.instruction_word[20:16]];
      end
      if (wb_go) begin
         rf_mem[s2_wb_idx_ff] <= s2_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff   <= '0;
         last_valid_ff <= 1'b0;
      end else if (wb_go) begin
         rf_valid_ff[s2_wb_idx_ff] <= 1'b1;
         last_valid_ff             <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_go) begin
         last_idx_ff <= s2_wb_idx_ff;
         last_val_ff <= s2_value;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pc_ff       <= '0;
         last_alu_ff <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_go) begin
            pc_ff       <= pc_in;
            last_alu_ff <= last_alu_in;
            stopped_ff  <= stopped_in;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_kind_ff  <= req_chan.item_kind;
         s1_insn_ff  <= req_chan.instruction_word;
         s1_haddr_ff <= req_chan.host_address;
         s1_hbyte_ff <= req_chan.host_byte;
      end
      if (s1_go) begin
         s2_pc_ff       <= pc_in;
         s2_halted_ff   <= stopped_in;
         s2_fault_ff    <= addr_fault;
         s2_wb_valid_ff <= wb_en;
         s2_wb_idx_ff   <= wb_en ? dest : '0;
         s2_alu_ff      <= alu_res;
         s2_load_ff     <= is_lw;
         s2_hread_ff    <= host_rd;
         s2_lane_ff     <= lane0;
      end
   end

   assign rsp_chan.valid           = s2_valid_ff;
   assign rsp_chan.next_pc         = s2_pc_ff;
   assign rsp_chan.halted          = s2_halted_ff;
   assign rsp_chan.fault           = s2_fault_ff;
   assign rsp_chan.writeback_valid = s2_wb_valid_ff;
   assign rsp_chan.writeback_index = s2_wb_idx_ff;
   assign rsp_chan.writeback_value = s2_wb_valid_ff ? s2_value : '0;
   assign rsp_chan.host_read_value = s2_hread_ff ? bank_rd_ff[s2_lane_ff] : '0;

endmodule

@@ dv/mips_subset_single_cycle_core_top_tb.sv @@
module mips_subset_single_cycle_core_top_tb;
   import mscore_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [2:0] ALU_REPEAT = 3'd0;
   localparam logic [2:0] FUNCT_HI   = 3'b100;
   localparam opcode_type OP_SPARE   = 6'h3F;
   localparam int         ROWS       = 25;

   typedef struct packed {
      logic [1:0]  kind;
      word_type    insn;
      logic [15:0] addr;
      logic [7:0]  data;
   } core_op_t;

   typedef struct packed {
      word_type      next_pc;
      logic          halted;
      logic          fault;
      logic          wb_valid;
      reg_index_type wb_index;
      word_type      wb_value;
      logic [7:0]    host_read;
   } retire_t;

   typedef struct packed {
      core_op_t stim;
      logic     typed;
      retire_t  want;
   } step_row_t;

   localparam step_row_t DIRECTED [ROWS] = '{
      '{'{KIND_SPARE, 32'h0, 16'h0, 8'h0},
        1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_EXEC, {OP_ADDIU, 5'd0, 5'd1, 16'hFFFF}, 16'h0, 8'h0},
        1'b1, '{32'd4, 1'b0, 1'b0, 1'b1, 5'd1, 32'h0000_FFFF, 8'h00}},
      '{'{KIND_EXEC, {OP_ADDIU, 5'd0, 5'd2, 16'h0001}, 16'h0, 8'h0},
        1'b1, '{32'd8, 1'b0, 1'b0, 1'b1, 5'd2, 32'h0000_0001, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FUNCT_HI, ALU_ADDU}, 16'h0, 8'h0},
        1'b1, '{32'd12, 1'b0, 1'b0, 1'b1, 5'd3, 32'h0001_0000, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd2, 5'd1, 5'd4, 5'd0, FUNCT_HI, ALU_SUBU}, 16'h0, 8'h0},
        1'b1, '{32'd16, 1'b0, 1'b0, 1'b1, 5'd4, 32'hFFFF_0002, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd4, 5'd5, 5'd0, FUNCT_HI, ALU_AND}, 16'h0, 8'h0},
        1'b1, '{32'd20, 1'b0, 1'b0, 1'b1, 5'd5, 32'h0000_0002, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd4, 5'd6, 5'd0, FUNCT_HI, ALU_OR}, 16'h0, 8'h0},
        1'b1, '{32'd24, 1'b0, 1'b0, 1'b1, 5'd6, 32'hFFFF_FFFF, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd2, 5'd7, 5'd0, FUNCT_HI, ALU_NOR}, 16'h0, 8'h0},
        1'b1, '{32'd28, 1'b0, 1'b0, 1'b1, 5'd7, 32'hFFFF_0000, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd2, 5'd8, 5'd0, FUNCT_HI, ALU_REPEAT}, 16'h0, 8'h0},
        1'b1, '{32'd32, 1'b0, 1'b0, 1'b1, 5'd8, 32'hFFFF_0000, 8'h00}},
      '{'{KIND_EXEC, {OP_RTYPE, 5'd1, 5'd2, 5'd0, 5'd0, FUNCT_HI, ALU_ADDU}, 16'h0, 8'h0},
        1'b1, '{32'd36, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_HOST_WRITE, 32'h0, 16'hFFFE, 8'hA5},
        1'b1, '{32'd36, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_HOST_WRITE, 32'h0, 16'hFFFF, 8'h5A},
        1'b1, '{32'd36, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_HOST_WRITE, 32'h0, 16'h0000, 8'h3C},
        1'b1, '{32'd36, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_HOST_WRITE, 32'h0, 16'h0001, 8'hC3},
        1'b1, '{32'd36, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h00}},
      '{'{KIND_EXEC, {OP_LW, 5'd1, 5'd9, 16'hFFFF}, 16'h0, 8'h0},
        1'b1, '{32'd40, 1'b0, 1'b0, 1'b1, 5'd9, 32'hA55A_3CC3, 8'h00}},
      '{'{KIND_HOST_READ, 32'h0, 16'hFFFF, 8'h0},
        1'b1, '{32'd40, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 8'h5A}},
      '{'{KIND_EXEC, {OP_SW, 5'd0, 5'd6, 16'h7FFC}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_LW, 5'd0, 5'd10, 16'h7FFC}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_BEQ, 5'd1, 5'd2, 16'h0004}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_BEQ, 5'd1, 5'd1, 16'h8000}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_J, 26'h3FF_FFFF}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_SPARE, 26'h3FF_FFFE}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF}, 1'b0, '0},
      '{'{KIND_EXEC, {OP_ADDIU, 5'd6, 5'd31, 16'hFFFF}, 16'h0, 8'h0}, 1'b0, '0},
      '{'{KIND_HOST_READ, 32'h0, 16'h0000, 8'h0}, 1'b0, '0}
   };

   logic clock;
   logic reset;

   mscore_req_if req_chan ();
   mscore_rsp_if rsp_chan ();

   mips_subset_single_cycle_core_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   word_type    core_regs [32] = '{default: '0};
   word_type    core_pc        = '0;
   word_type    last_alu       = '0;
   bit          core_stopped   = 1'b0;
   logic [7:0]  data_mem [int];
   logic [15:0] byte_addrs [$];
   logic [15:0] word_starts [$];

   retire_t retire_q [$];
   int      mismatches      = 0;
   int      source_idle_pct = 0;
   int      sink_stall_pct  = 0;

   function automatic word_type alu_eval(logic [2:0] op, word_type a, word_type b);
      case (op)
         ALU_ADDU: last_alu = a + b;
         ALU_SUBU: last_alu = a - b;
         ALU_AND:  last_alu = a & b;
         ALU_OR:   last_alu = a | b;
         ALU_NOR:  last_alu = ~(a | b);
         default: ;
      endcase
      return last_alu;
   endfunction

   function automatic void store_byte(logic [15:0] addr, logic [7:0] data);
      if (!data_mem.exists(int'(addr))) byte_addrs.push_back(addr);
      data_mem[int'(addr)] = data;
   endfunction

   function automatic retire_t core_step(core_op_t op);
      retire_t       r;
      word_type      a, b, simm, ea, value;
      opcode_type    opcode;
      reg_index_type dest;
      bit            rf_write;
      r = '0;
      case (op.kind)
         KIND_HOST_WRITE: store_byte(op.addr, op.data);
         KIND_HOST_READ:  r.host_read = data_mem[int'(op.addr)];
         KIND_EXEC: begin
            if (!core_stopped && op.insn == HALT_WORD) begin
               core_stopped = 1'b1;
            end else if (!core_stopped) begin
               opcode   = op.insn[31:26];
               a        = core_regs[op.insn[25:21]];
               b        = core_regs[op.insn[20:16]];
               simm     = {{16{op.insn[15]}}, op.insn[15:0]};
               rf_write = 1'b0;
               dest     = '0;
               value    = '0;
               case (opcode)
                  OP_RTYPE: begin
                     value    = alu_eval(op.insn[2:0], a, b);
                     dest     = op.insn[15:11];
                     rf_write = 1'b1;
                  end
                  OP_ADDIU: begin
                     value    = alu_eval(ALU_ADDU, a, {16'h0, op.insn[15:0]});
                     dest     = op.insn[20:16];
                     rf_write = 1'b1;
                  end
                  OP_LW, OP_SW: begin
                     ea = alu_eval(ALU_ADDU, a, simm);
                     if (ea > LOAD_ADDR_MAX) begin
                        core_stopped = 1'b1;
                        r.fault      = 1'b1;
                     end else if (opcode == OP_LW) begin
                        for (int i = 0; i < 4; i++)
                           value = {value[23:0], data_mem[int'(16'(ea + i))]};
                        dest     = op.insn[20:16];
                        rf_write = 1'b1;
                     end else begin
                        for (int i = 0; i < 4; i++)
                           store_byte(16'(ea + i), b[8 * (3 - i) +: 8]);
                        word_starts.push_back(ea[15:0]);
                     end
                  end
                  default: ;
               endcase
               if (!r.fault) begin
                  if (rf_write && dest != 0) begin
                     core_regs[dest] = value;
                     r.wb_valid      = 1'b1;
                     r.wb_index      = dest;
                     r.wb_value      = value;
                  end
                  if (opcode == OP_BEQ && a == b)
                     core_pc = core_pc + PC_STEP + (simm << 2);
                  else if (opcode == OP_J)
                     core_pc = ((core_pc + PC_STEP) & 32'hF000_0000) |
                               {4'h0, op.insn[25:0], 2'b00};
                  else
                     core_pc = core_pc + PC_STEP;
               end
            end
         end
         default: ;
      endcase
      r.next_pc = core_pc;
      r.halted  = core_stopped;
      return r;
   endfunction

   // A random word is only sent if it neither stops the core nor reads an unwritten data byte.
   function automatic bit item_ok(core_op_t op);
      word_type ea;
      if (op.kind == KIND_HOST_READ) return data_mem.exists(int'(op.addr));
      if (op.kind != KIND_EXEC || core_stopped) return 1'b1;
      if (op.insn == HALT_WORD) return 1'b0;
      if (op.insn[31:26] != OP_LW && op.insn[31:26] != OP_SW) return 1'b1;
      ea = core_regs[op.insn[25:21]] + {{16{op.insn[15]}}, op.insn[15:0]};
      if (ea > LOAD_ADDR_MAX) return 1'b0;
      if (op.insn[31:26] == OP_SW) return 1'b1;
      for (int i = 0; i < 4; i++)
         if (!data_mem.exists(int'(16'(ea + i)))) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit find_base(input logic [15:0] target, output reg_index_type base,
                                    output logic [15:0] offs);
      word_type diff;
      int       start;
      start = $urandom_range(31);
      base  = '0;
      offs  = '0;
      for (int k = 0; k < 32; k++) begin
         base = 5'(start + k);
         diff = {16'h0, target} - core_regs[base];
         if (diff + 32'h0000_8000 < 32'h0001_0000) begin
            offs = diff[15:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic make_random(output core_op_t op);
      int            pick;
      logic [15:0]   target;
      reg_index_type base;
      logic [15:0]   offs;
      for (int tries = 0; tries < 16; tries++) begin
         pick    = $urandom_range(99);
         op.kind = KIND_EXEC;
         op.insn = $urandom;
         op.addr = 16'($urandom);
         op.data = 8'($urandom);
         if (pick < 35) begin
            op.insn[31:26] = OP_RTYPE;
         end else if (pick < 50) begin
            op.insn[31:26] = OP_ADDIU;
            if ($urandom_range(1) == 0) op.insn[25:21] = '0;
         end else if (pick < 74) begin
            if (pick >= 62 && word_starts.size() > 0)
               target = word_starts[$urandom_range(word_starts.size() - 1)];
            else if ($urandom_range(7) == 0)
               target = 16'hFFFC + 16'($urandom_range(3));
            else
               target = 16'($urandom);
            if (find_base(target, base, offs)) begin
               op.insn[25:21] = base;
               op.insn[15:0]  = offs;
               if (pick < 62) op.insn[31:26] = OP_SW;
               else           op.insn[31:26] = OP_LW;
            end
         end else if (pick < 79) begin
            op.insn[31:26] = OP_BEQ;
            if ($urandom_range(1) == 0) op.insn[20:16] = op.insn[25:21];
         end else if (pick < 82) begin
            op.insn[31:26] = OP_J;
         end else if (pick < 90) begin
            op.kind = KIND_HOST_WRITE;
         end else if (pick < 96) begin
            op.kind = KIND_HOST_READ;
            if (byte_addrs.size() > 0)
               op.addr = byte_addrs[$urandom_range(byte_addrs.size() - 1)];
         end else if (pick < 98) begin
            op.kind = KIND_SPARE;
         end
         if (item_ok(op)) return;
      end
      op.kind        = KIND_EXEC;
      op.insn[31:26] = OP_RTYPE;
   endtask

   task automatic offer(input core_op_t op, input logic typed, input retire_t want);
      retire_t outcome;
      while ($urandom_range(99) < source_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.item_kind        <= op.kind;
      req_chan.instruction_word <= op.insn;
      req_chan.host_address     <= op.addr;
      req_chan.host_byte        <= op.data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      outcome = core_step(op);
      retire_q.push_back(typed ? want : outcome);
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (retire_q.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 200_000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      retire_t seen;
      retire_t want;
      int      results_seen;
      int      hold_left;
      results_seen = 0;
      hold_left    = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.next_pc, rsp_chan.halted, rsp_chan.fault,
                     rsp_chan.writeback_valid, rsp_chan.writeback_index,
                     rsp_chan.writeback_value, rsp_chan.host_read_value};
            results_seen++;
            if (retire_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected word %0d: pc %h halted %b fault %b wb %b %0d %h rd %h",
                           results_seen, seen.next_pc, seen.halted, seen.fault,
                           seen.wb_valid, seen.wb_index, seen.wb_value, seen.host_read);
            end else begin
               want = retire_q.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Word %0d expected: pc %h halted %b fault %b wb %b %0d %h rd %h",
                              results_seen, want.next_pc, want.halted, want.fault,
                              want.wb_valid, want.wb_index, want.wb_value, want.host_read);
                     $display("Word %0d actual:   pc %h halted %b fault %b wb %b %0d %h rd %h",
                              results_seen, seen.next_pc, seen.halted, seen.fault,
                              seen.wb_valid, seen.wb_index, seen.wb_value, seen.host_read);
                  end
               end
            end
            // One long hold-off whilst the sender keeps offering, so that the core fills up.
            if (results_seen == 100) hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   initial begin
      core_op_t op;
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.item_kind        <= KIND_EXEC;
      req_chan.instruction_word <= '0;
      req_chan.host_address     <= '0;
      req_chan.host_byte        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         offer(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin source_idle_pct = 64; sink_stall_pct = 0;  end
            2: begin source_idle_pct = 0;  sink_stall_pct = 64; end
            default: begin source_idle_pct = 20; sink_stall_pct = 20; end
         endcase
         for (int n = 0; n < 210; n++) begin
            make_random(op);
            offer(op, 1'b0, '0);
         end
         if (phase == 1) drain();
      end
      // The core stops for good here, by a halt word or by a faulting load or store.
      op = '{KIND_EXEC, HALT_WORD, 16'h0, 8'h0};
      case ($urandom_range(2))
         0: op.insn = {OP_LW, 5'd0, 5'd1, 16'h8000};
         1: op.insn = {OP_SW, 5'd0, 5'd2, 16'hFFFC};
         default: ;
      endcase
      offer(op, 1'b0, '0);
      offer('{KIND_EXEC, HALT_WORD, 16'h0, 8'h0}, 1'b0, '0);
      for (int n = 0; n < 12; n++) begin
         make_random(op);
         offer(op, 1'b0, '0);
      end
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && retire_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ mips_subset_single_cycle_core_top.f @@
hdl/mscore_pkg.sv
hdl/mscore_if.sv
hdl/mips_subset_single_cycle_core_top.sv
dv/mips_subset_single_cycle_core_top_tb.sv
